// ===== rtl/qss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qss_pkg
// Shared widths, constants, the CORDIC arctangent table and the request
// context that travels down the interpolation pipeline.
// ----------------------------------------------------------------------------
package qss_pkg;

    localparam int CB       = 16;        // component width, Q1.15
    localparam int FB       = 16;        // fraction bits of t
    localparam int TW       = FB + 1;    // width of t_frac
    localparam int SW       = 5;         // width of spin
    localparam int CSTEPS   = 30;        // CORDIC iterations
    localparam int SQ_STEPS = 31;        // square root result bits
    localparam int DIV_BITS = 48;        // quotient bits per divider
    localparam int ROT_LAT  = CSTEPS + 1;
    localparam int DIV_LAT  = DIV_BITS + 2;

    localparam logic [15:0]        THR_RESET = 16'd1074;
    localparam logic signed [33:0] GAIN      = 34'sh026DD3B6A;
    localparam logic [47:0]        W_LIM     = 48'd1 << 46;

    // atan(2^-i) in binary-angle units, one turn = 2^32
    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sh20000000;
            5'd1:  v = 34'sh12E4051E;
            5'd2:  v = 34'sh09FB385B;
            5'd3:  v = 34'sh051111D4;
            5'd4:  v = 34'sh028B0D43;
            5'd5:  v = 34'sh0145D7E1;
            5'd6:  v = 34'sh00A2F61E;
            5'd7:  v = 34'sh00517C55;
            5'd8:  v = 34'sh0028BE53;
            5'd9:  v = 34'sh00145F2F;
            5'd10: v = 34'sh000A2F98;
            5'd11: v = 34'sh000517CC;
            5'd12: v = 34'sh00028BE6;
            5'd13: v = 34'sh000145F3;
            5'd14: v = 34'sh0000A2FA;
            5'd15: v = 34'sh0000517D;
            5'd16: v = 34'sh000028BE;
            5'd17: v = 34'sh0000145F;
            5'd18: v = 34'sh00000A30;
            5'd19: v = 34'sh00000518;
            5'd20: v = 34'sh0000028C;
            5'd21: v = 34'sh00000146;
            5'd22: v = 34'sh000000A3;
            5'd23: v = 34'sh00000051;
            5'd24: v = 34'sh00000029;
            5'd25: v = 34'sh00000014;
            5'd26: v = 34'sh0000000A;
            5'd27: v = 34'sh00000005;
            5'd28: v = 34'sh00000003;
            5'd29: v = 34'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic                 valid;
        logic [3:0][CB-1:0]   p;
        logic [3:0][CB-1:0]   q;
        logic [TW-1:0]        t;
        logic [SW-1:0]        spin;
        logic                 flip;
        logic                 linear;
        logic [30:0]          s;
    } t_ctx;

endpackage
`default_nettype wire

// ===== rtl/quaternion_slerp_spins.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_slerp_spins
// Fixed-point quaternion slerp with extra half-turn spins.
// ----------------------------------------------------------------------------
// The block takes one request per clock while o_stall is low and returns one
// result per request, in order. The pipeline holds the bit-per-stage square
// root (31 stages), the vectoring CORDIC (30), the rotation CORDICs (31) and
// the quotient dividers (50), plus the stages of input, product, dot product,
// cosine squared, angle scaling, weight select, multiply and rounding.
// A stall on the output freezes the whole pipeline; nothing is dropped or
// repeated.
module quaternion_slerp_spins (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [15:0] i_p_w,
    input  wire  [15:0] i_p_x,
    input  wire  [15:0] i_p_y,
    input  wire  [15:0] i_p_z,
    input  wire  [15:0] i_q_w,
    input  wire  [15:0] i_q_x,
    input  wire  [15:0] i_q_y,
    input  wire  [15:0] i_q_z,
    input  wire  [16:0] i_t_frac,
    input  wire  [4:0]  i_spin,
    input  wire         i_cfg_we,
    input  wire  [15:0] i_cfg_wdata,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [15:0] o_r_w,
    output logic [15:0] o_r_x,
    output logic [15:0] o_r_y,
    output logic [15:0] o_r_z,
    output logic        o_linear_used,
    output logic        o_saturated
);

    localparam int SQ = qss_pkg::SQ_STEPS;
    localparam int AT = qss_pkg::CSTEPS;
    localparam int RL = qss_pkg::ROT_LAT;
    localparam int DL = qss_pkg::DIV_LAT;
    localparam logic [61:0] SQ_TOP = 62'd1 << 60;

    logic        en;
    logic [15:0] r_thr;
    logic        r_out_valid;

    qss_pkg::t_ctx r_a, r_b, r_c, r_d, r_t1, r_t2, r_w, r_p;
    qss_pkg::t_ctx r_sq_ctx  [SQ];
    qss_pkg::t_ctx r_at_ctx  [AT];
    qss_pkg::t_ctx r_rot_ctx [RL];
    qss_pkg::t_ctx r_div_ctx [DL];
    qss_pkg::t_ctx n_at_ctx;
    qss_pkg::t_ctx n_c;

    logic signed [31:0] r_prod [4];
    logic signed [33:0] n_cos_sum;
    logic [33:0]        n_cos_abs;
    logic signed [34:0] n_diff;
    logic [30:0]        r_c_cos, r_d_cos;
    logic [61:0]        r_d_sq;

    logic [61:0] r_sq_n   [SQ];
    logic [61:0] r_sq_r   [SQ];
    logic [30:0] r_sq_cos [SQ];

    logic signed [35:0] r_at_x [AT];
    logic signed [35:0] r_at_y [AT];
    logic signed [33:0] r_at_z [AT];

    logic signed [37:0] n_phi;
    logic signed [55:0] r_t1_prod, n_rnd;
    logic signed [33:0] r_t1_theta;
    logic [39:0]        n_tphi;
    logic [31:0]        r_t2_a1, r_t2_a2;

    logic signed [33:0] sin1, sin2;
    logic signed [47:0] w_beta, w_alpha;
    logic signed [47:0] n_alpha_lin, n_beta, n_alpha;
    logic signed [47:0] r_w_beta, r_w_alpha;
    logic signed [63:0] r_pb [4];
    logic signed [63:0] r_pa [4];

    logic [3:0][15:0] n_res;
    logic [3:0]       n_sat;
    logic [3:0][15:0] r_res;
    logic             r_lin, r_sat;

    // whole pipeline holds while a result waits on a stalled output
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= qss_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // input, products, dot product, cosine squared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
            r_c.valid <= 1'b0;
            r_d.valid <= 1'b0;
        end else if (en) begin
            r_a.valid  <= i_valid;
            r_a.p      <= {i_p_z, i_p_y, i_p_x, i_p_w};
            r_a.q      <= {i_q_z, i_q_y, i_q_x, i_q_w};
            r_a.t      <= i_t_frac;
            r_a.spin   <= i_spin;
            r_a.flip   <= 1'b0;
            r_a.linear <= 1'b0;
            r_a.s      <= '0;
            r_b        <= r_a;
            for (int i = 0; i < 4; i++) begin
                r_prod[i] <= $signed(r_a.p[i]) * $signed(r_a.q[i]);
            end
            r_c        <= n_c;
            r_c_cos    <= n_cos_abs[30:0];
            r_d        <= r_c;
            r_d_cos    <= r_c_cos;
            r_d_sq     <= r_c_cos * r_c_cos;
        end
    end

    assign n_cos_sum = 34'(r_prod[0]) + 34'(r_prod[1]) + 34'(r_prod[2]) + 34'(r_prod[3]);
    assign n_cos_abs = n_cos_sum[33] ? 34'(-n_cos_sum) : 34'(n_cos_sum);
    assign n_diff    = 35'sd1073741824 - $signed({1'b0, n_cos_abs});

    always_comb begin
        n_c        = r_b;
        n_c.flip   = n_cos_sum[33];
        n_c.linear = (n_diff < $signed({19'd0, r_thr}));
    end

    // sine of theta: floor square root of 2^60 - cos^2, one bit per stage
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
        logic [61:0]   n_prev, r_prev, trial;
        logic [30:0]   cos_prev;
        qss_pkg::t_ctx c_prev;
        if (k == 0) begin : g_first
            assign n_prev   = SQ_TOP - r_d_sq;
            assign r_prev   = '0;
            assign cos_prev = r_d_cos;
            assign c_prev   = r_d;
        end else begin : g_next
            assign n_prev   = r_sq_n[k-1];
            assign r_prev   = r_sq_r[k-1];
            assign cos_prev = r_sq_cos[k-1];
            assign c_prev   = r_sq_ctx[k-1];
        end
        assign trial = r_prev + BIT;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_ctx[k].valid <= 1'b0;
            end else if (en) begin
                r_sq_ctx[k] <= c_prev;
                r_sq_cos[k] <= cos_prev;
                if (n_prev >= trial) begin
                    r_sq_n[k] <= n_prev - trial;
                    r_sq_r[k] <= (r_prev >> 1) + BIT;
                end else begin
                    r_sq_n[k] <= n_prev;
                    r_sq_r[k] <= r_prev >> 1;
                end
            end
        end
    end

    always_comb begin
        n_at_ctx        = r_sq_ctx[SQ-1];
        n_at_ctx.s      = r_sq_r[SQ-1][30:0];
        n_at_ctx.linear = r_sq_ctx[SQ-1].linear || (r_sq_r[SQ-1][30:0] == 31'd0);
    end

    // theta = atan2(sin, cos), vectoring CORDIC
    for (genvar k = 0; k < AT; k++) begin : g_atan
        logic signed [35:0] x_prev, y_prev;
        logic signed [33:0] z_prev;
        qss_pkg::t_ctx      c_prev;
        if (k == 0) begin : g_first
            assign x_prev = $signed({5'd0, r_sq_cos[SQ-1]});
            assign y_prev = $signed({5'd0, r_sq_r[SQ-1][30:0]});
            assign z_prev = '0;
            assign c_prev = n_at_ctx;
        end else begin : g_next
            assign x_prev = r_at_x[k-1];
            assign y_prev = r_at_y[k-1];
            assign z_prev = r_at_z[k-1];
            assign c_prev = r_at_ctx[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_at_ctx[k].valid <= 1'b0;
            end else if (en) begin
                r_at_ctx[k] <= c_prev;
                if (!y_prev[35]) begin
                    r_at_x[k] <= x_prev + (y_prev >>> k);
                    r_at_y[k] <= y_prev - (x_prev >>> k);
                    r_at_z[k] <= z_prev + qss_pkg::atan_turn(5'(k));
                end else begin
                    r_at_x[k] <= x_prev - (y_prev >>> k);
                    r_at_y[k] <= y_prev + (x_prev >>> k);
                    r_at_z[k] <= z_prev - qss_pkg::atan_turn(5'(k));
                end
            end
        end
    end

    // phi = theta + spin * pi, then t * phi rounded
    assign n_phi = {{4{r_at_z[AT-1][33]}}, r_at_z[AT-1]}
                 + $signed({{2{r_at_ctx[AT-1].spin[4]}}, r_at_ctx[AT-1].spin, 31'd0});
    assign n_rnd  = r_t1_prod + 56'sd32768;
    assign n_tphi = n_rnd[55:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.valid <= 1'b0;
            r_t2.valid <= 1'b0;
        end else if (en) begin
            r_t1       <= r_at_ctx[AT-1];
            r_t1_theta <= r_at_z[AT-1];
            r_t1_prod  <= $signed({1'b0, r_at_ctx[AT-1].t}) * n_phi;
            r_t2       <= r_t1;
            r_t2_a1    <= r_t1_theta[31:0] - n_tphi[31:0];
            r_t2_a2    <= n_tphi[31:0];
        end
    end

    qss_rot u_rot1 (.i_clk(i_clk), .i_en(en), .i_angle(r_t2_a1), .o_sin(sin1));
    qss_rot u_rot2 (.i_clk(i_clk), .i_en(en), .i_angle(r_t2_a2), .o_sin(sin2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RL; k++) begin
                r_rot_ctx[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_rot_ctx[0] <= r_t2;
            for (int k = 1; k < RL; k++) begin
                r_rot_ctx[k] <= r_rot_ctx[k-1];
            end
        end
    end

    qss_div u_div1 (
        .i_clk(i_clk), .i_en(en), .i_num(sin1), .i_den(r_rot_ctx[RL-1].s), .o_quo(w_beta)
    );
    qss_div u_div2 (
        .i_clk(i_clk), .i_en(en), .i_num(sin2), .i_den(r_rot_ctx[RL-1].s), .o_quo(w_alpha)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DL; k++) begin
                r_div_ctx[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_div_ctx[0] <= r_rot_ctx[RL-1];
            for (int k = 1; k < DL; k++) begin
                r_div_ctx[k] <= r_div_ctx[k-1];
            end
        end
    end

    // pick linear or slerp weights, apply the flip
    always_comb begin
        n_alpha_lin = $signed({17'd0, r_div_ctx[DL-1].t, 14'd0});
        if (r_div_ctx[DL-1].linear) begin
            n_alpha = n_alpha_lin;
            n_beta  = 48'sd1073741824 - n_alpha_lin;
        end else begin
            n_alpha = w_alpha;
            n_beta  = w_beta;
        end
        if (r_div_ctx[DL-1].flip) begin
            n_alpha = -n_alpha;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic signed [63:0] acc;
            logic signed [33:0] rr;
            acc      = r_pb[i] + r_pa[i] + 64'sd536870912;
            rr       = acc[63:30];
            n_sat[i] = 1'b0;
            n_res[i] = rr[15:0];
            if (rr > 34'sd32767) begin
                n_res[i] = 16'h7FFF;
                n_sat[i] = 1'b1;
            end else if (rr < -34'sd32768) begin
                n_res[i] = 16'h8000;
                n_sat[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w.valid   <= 1'b0;
            r_p.valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_w       <= r_div_ctx[DL-1];
            r_w_beta  <= n_beta;
            r_w_alpha <= n_alpha;
            r_p       <= r_w;
            for (int i = 0; i < 4; i++) begin
                r_pb[i] <= r_w_beta * $signed(r_w.p[i]);
                r_pa[i] <= r_w_alpha * $signed(r_w.q[i]);
            end
            r_out_valid <= r_p.valid;
            r_res       <= n_res;
            r_lin       <= r_p.linear;
            r_sat       <= |n_sat;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_r_w         = r_res[0];
    assign o_r_x         = r_res[1];
    assign o_r_y         = r_res[2];
    assign o_r_z         = r_res[3];
    assign o_linear_used = r_lin;
    assign o_saturated   = r_sat;

endmodule
`default_nettype wire

// ===== rtl/qss_rot.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qss_rot
// Pipelined rotation CORDIC: sine of a binary angle in Q.30, one fold stage
// followed by one register stage per iteration.
// ----------------------------------------------------------------------------
module qss_rot (
    input  wire                i_clk,
    input  wire                i_en,
    input  wire [31:0]         i_angle,
    output logic signed [33:0] o_sin
);

    localparam int N = qss_pkg::CSTEPS;

    logic signed [33:0] n_z0;
    logic signed [33:0] r_z0;
    logic signed [33:0] r_x [N];
    logic signed [33:0] r_y [N];
    logic signed [33:0] r_z [N];

    // fold into [-pi/2, pi/2]
    always_comb begin
        n_z0 = 34'($signed(i_angle));
        if (n_z0 > 34'sh040000000) begin
            n_z0 = 34'sh080000000 - n_z0;
        end else if (n_z0 < -34'sh040000000) begin
            n_z0 = -34'sh080000000 - n_z0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0 <= n_z0;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic signed [33:0] x_prev, y_prev, z_prev;
        if (k == 0) begin : g_first
            assign x_prev = qss_pkg::GAIN;
            assign y_prev = '0;
            assign z_prev = r_z0;
        end else begin : g_next
            assign x_prev = r_x[k-1];
            assign y_prev = r_y[k-1];
            assign z_prev = r_z[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_prev[33]) begin
                    r_x[k] <= x_prev - (y_prev >>> k);
                    r_y[k] <= y_prev + (x_prev >>> k);
                    r_z[k] <= z_prev - qss_pkg::atan_turn(5'(k));
                end else begin
                    r_x[k] <= x_prev + (y_prev >>> k);
                    r_y[k] <= y_prev - (x_prev >>> k);
                    r_z[k] <= z_prev + qss_pkg::atan_turn(5'(k));
                end
            end
        end
    end

    assign o_sin = r_y[N-1];

endmodule
`default_nettype wire

// ===== rtl/qss_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qss_div
// Pipelined restoring divider: (num * 2^30) / den, truncated toward zero and
// clipped to +-2^46. One quotient bit per register stage.
// ----------------------------------------------------------------------------
module qss_div (
    input  wire                i_clk,
    input  wire                i_en,
    input  wire signed [33:0]  i_num,
    input  wire [30:0]         i_den,
    output logic signed [47:0] o_quo
);

    localparam int N = qss_pkg::DIV_BITS;

    logic [33:0] n_mag;
    logic [63:0] n_dvd;
    logic [47:0] r_dvd;
    logic [31:0] r_rem0;
    logic [30:0] r_den0;
    logic        r_neg0, r_ovf0;

    logic [31:0] r_rem [N];
    logic [47:0] r_q   [N];
    logic [30:0] r_den [N];
    logic [47:0] r_dv  [N];
    logic        r_neg [N];
    logic        r_ovf [N];

    logic [47:0] n_mq;

    assign n_mag = i_num[33] ? 34'(-i_num) : 34'(i_num);
    assign n_dvd = {n_mag, 30'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dvd  <= n_dvd[47:0];
            r_rem0 <= {16'd0, n_dvd[63:48]};
            r_den0 <= i_den;
            r_neg0 <= i_num[33];
            r_ovf0 <= ({15'd0, n_dvd[63:48]} >= i_den);
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_bit
        logic [31:0] rem_prev, rem2;
        logic [47:0] q_prev, dv_prev;
        logic [30:0] den_prev;
        logic        neg_prev, ovf_prev, ge;
        if (k == 0) begin : g_first
            assign rem_prev = r_rem0;
            assign q_prev   = '0;
            assign dv_prev  = r_dvd;
            assign den_prev = r_den0;
            assign neg_prev = r_neg0;
            assign ovf_prev = r_ovf0;
        end else begin : g_next
            assign rem_prev = r_rem[k-1];
            assign q_prev   = r_q[k-1];
            assign dv_prev  = r_dv[k-1];
            assign den_prev = r_den[k-1];
            assign neg_prev = r_neg[k-1];
            assign ovf_prev = r_ovf[k-1];
        end
        assign rem2 = {rem_prev[30:0], dv_prev[N-1-k]};
        assign ge   = (rem2 >= {1'b0, den_prev});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? (rem2 - {1'b0, den_prev}) : rem2;
                r_q[k]   <= {q_prev[46:0], ge};
                r_dv[k]  <= dv_prev;
                r_den[k] <= den_prev;
                r_neg[k] <= neg_prev;
                r_ovf[k] <= ovf_prev;
            end
        end
    end

    always_comb begin
        if (r_ovf[N-1] || (r_q[N-1] > qss_pkg::W_LIM)) begin
            n_mq = qss_pkg::W_LIM;
        end else begin
            n_mq = r_q[N-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quo <= r_neg[N-1] ? -$signed(n_mq) : $signed(n_mq);
        end
    end

endmodule
`default_nettype wire
